### sv/mbt_pkg.sv
// Shared types and constants of the Mandelbrot escape-time block.
package mbt_pkg;

  localparam int unsigned QW      = 32;  // signed Q4.28 coordinate width
  localparam int unsigned STEPW   = 31;  // unsigned Q3.28 step width
  localparam int unsigned MAGW    = 32;  // unsigned Q8.24 magnitude width
  localparam int unsigned OPW     = 32;  // multiplier operand width
  localparam int unsigned PRODW   = 64;  // multiplier product width
  localparam int unsigned LANES   = 3;   // multiplier lanes in the shared unit
  localparam int unsigned WW      = 38;  // width of the floored square terms
  localparam int unsigned ZW      = 39;  // width of a new orbit component
  localparam int unsigned CFG_IW  = 3;   // register index width
  localparam int unsigned CFG_DW  = 32;  // register data width

  localparam logic [QW-1:0]   Q_MAX   = 32'h7FFF_FFFF;
  localparam logic [QW-1:0]   Q_MIN   = 32'h8000_0000;
  localparam logic [MAGW-1:0] MAG_SAT = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IW-1:0] {
    CFG_LEFT_EDGE   = 3'd0,
    CFG_TOP_EDGE    = 3'd1,
    CFG_COLUMN_STEP = 3'd2,
    CFG_ROW_STEP    = 3'd3,
    CFG_MAX_ITER    = 3'd4,
    CFG_ESCAPE_SQ   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_CSET,
    ST_ADD,
    ST_MUL,
    ST_CMP,
    ST_DONE
  } state_e;

  typedef enum logic {
    MSEL_MAP,
    MSEL_SQ
  } mul_sel_e;

  typedef logic [LANES-1:0][OPW-1:0]   mul_ops_t;
  typedef logic [LANES-1:0][PRODW-1:0] mul_prods_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic     take_xy;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     load_c;
    logic     clear_w;
    logic     load_w;
    logic     load_z;
  } ctl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic            huge;
    logic            ovf;
    logic            over;
    logic [MAGW-1:0] sum_hi;
  } sts_t;

endpackage

### sv/mbt_mul3.sv
// Shared three-lane 32x32 unsigned multiplier with registered products.
module mbt_mul3 (
  input  logic                clk_i,
  input  logic                en_i,
  input  mbt_pkg::mul_ops_t   a_i,
  input  mbt_pkg::mul_ops_t   b_i,
  output mbt_pkg::mul_prods_t p_o
);
  import mbt_pkg::*;

  mul_prods_t p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < LANES; k++) begin
        p_q[k] <= PRODW'(a_i[k]) * PRODW'(b_i[k]);
      end
    end
  end

  assign p_o = p_q;

endmodule

### sv/mbt_orbit.sv
// Datapath: point mapping, orbit registers and escape tests around the shared multiplier.
module mbt_orbit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  mbt_pkg::ctl_t                   ctl_i,
  input  logic [COORD_BITS-1:0]           column_i,
  input  logic [COORD_BITS-1:0]           row_i,
  input  logic [mbt_pkg::QW-1:0]          left_edge_i,
  input  logic [mbt_pkg::QW-1:0]          top_edge_i,
  input  logic [mbt_pkg::STEPW-1:0]       column_step_i,
  input  logic [mbt_pkg::STEPW-1:0]       row_step_i,
  input  logic [mbt_pkg::MAGW-1:0]        escape_sq_i,
  output mbt_pkg::sts_t                   sts_o
);
  import mbt_pkg::*;

  localparam int unsigned PW = COORD_BITS + STEPW;  // mapping product width
  localparam int unsigned SW = PW + 2;              // mapping sum width

  logic [COORD_BITS-1:0] col_q, row_q;
  logic [QW-1:0]         cre_q, cim_q;
  logic signed [WW-1:0]  re_q, im_q;
  logic [OPW-1:0]        ar_q, ai_q;
  logic                  zneg_q;

  mul_ops_t   mul_a, mul_b;
  mul_prods_t prod;

  logic signed [SW-1:0] cre_full, cim_full;
  logic [QW-1:0]        cre_d, cim_d;
  logic signed [64:0]   diff;
  logic [64:0]          pmag, pp;
  logic signed [ZW-1:0] zr, zi;
  logic [ZW-1:0]        zr_mag, zi_mag;
  logic [64:0]          sum;

  function automatic logic [QW-1:0] sat_q(input logic [SW-1:0] v);
    logic [QW-1:0] r;
    if (v[SW-1:QW-1] != {(SW-QW+1){v[QW-1]}}) begin
      r = v[SW-1] ? Q_MIN : Q_MAX;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl_i.mul_sel)
      MSEL_MAP: begin
        mul_a[0] = OPW'(col_q);
        mul_b[0] = OPW'(column_step_i);
        mul_a[1] = OPW'(row_q);
        mul_b[1] = OPW'(row_step_i);
      end
      MSEL_SQ: begin
        mul_a[0] = ar_q;
        mul_b[0] = ar_q;
        mul_a[1] = ai_q;
        mul_b[1] = ai_q;
        mul_a[2] = ar_q;
        mul_b[2] = ai_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mbt_mul3 u_mul (
    .clk_i (clk_i),
    .en_i  (ctl_i.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    cre_full = $signed({{(SW-QW){left_edge_i[QW-1]}}, left_edge_i})
             + $signed({2'b00, prod[0][PW-1:0]});
    cim_full = $signed({{(SW-QW){top_edge_i[QW-1]}}, top_edge_i})
             - $signed({2'b00, prod[1][PW-1:0]});
    cre_d    = sat_q(cre_full);
    cim_d    = sat_q(cim_full);

    // Real part: floor((zr^2 - zi^2) / 2^28). Imaginary: floor(2*zr*zi / 2^28).
    diff = $signed({1'b0, prod[0]}) - $signed({1'b0, prod[1]});
    pmag = {1'b0, prod[2]};
    pp   = zneg_q ? (~pmag + 65'd1) : pmag;

    zr = $signed({re_q[WW-1], re_q}) + $signed({{(ZW-QW){cre_q[QW-1]}}, cre_q});
    zi = $signed({im_q[WW-1], im_q}) + $signed({{(ZW-QW){cim_q[QW-1]}}, cim_q});
    zr_mag = zr[ZW-1] ? (~zr + ZW'(1)) : zr;
    zi_mag = zi[ZW-1] ? (~zi + ZW'(1)) : zi;

    sum = {1'b0, prod[0]} + {1'b0, prod[1]};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take_xy) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    if (ctl_i.load_c) begin
      cre_q <= cre_d;
      cim_q <= cim_d;
    end
    if (ctl_i.clear_w) begin
      re_q <= '0;
      im_q <= '0;
    end else if (ctl_i.load_w) begin
      re_q <= $signed({diff[64], diff[64:28]});
      im_q <= $signed(pp[64:27]);
    end
    if (ctl_i.load_z) begin
      ar_q   <= zr_mag[OPW-1:0];
      ai_q   <= zi_mag[OPW-1:0];
      zneg_q <= zr[ZW-1] ^ zi[ZW-1];
    end
  end

  // A component of 16 or more in magnitude escapes at once.
  assign sts_o.huge   = (|zr_mag[ZW-1:OPW]) | (|zi_mag[ZW-1:OPW]);
  assign sts_o.ovf    = sum[64];
  assign sts_o.over   = sum[63:0] > {escape_sq_i, 32'h0000_0000};
  assign sts_o.sum_hi = sum[63:32];

endmodule

### sv/mbt_ctrl.sv
// Sequencer: handshakes, iteration count, result capture and output register.
module mbt_ctrl #(
  parameter int unsigned ITER_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ITER_BITS-1:0]       max_iter_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output mbt_pkg::ctl_t              ctl_o,
  input  mbt_pkg::sts_t              sts_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       out_esc_o,
  output logic [ITER_BITS-1:0]       out_step_o,
  output logic [mbt_pkg::MAGW-1:0]   out_mag_o
);
  import mbt_pkg::*;

  state_e               state_q, state_d;
  logic [ITER_BITS-1:0] iter_q, iter_d;
  logic                 res_esc_q, res_esc_d;
  logic [ITER_BITS-1:0] res_step_q, res_step_d;
  logic [MAGW-1:0]      res_mag_q, res_mag_d;
  logic                 res_load;
  logic                 out_load;
  logic                 m_valid_q, m_valid_d;
  logic                 m_esc_q;
  logic [ITER_BITS-1:0] m_step_q;
  logic [MAGW-1:0]      m_mag_q;
  logic                 last_iter;
  logic                 out_free;

  assign last_iter = ITER_BITS'(iter_q + 1'b1) == max_iter_i;
  assign out_free  = !m_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MAP;
      ST_MAP:  state_d = ST_CSET;
      ST_CSET: state_d = (max_iter_i == '0) ? ST_DONE : ST_ADD;
      ST_ADD:  state_d = sts_i.huge ? ST_DONE : ST_MUL;
      ST_MUL:  state_d = ST_CMP;
      ST_CMP: begin
        if (sts_i.ovf || sts_i.over || last_iter) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctl_o      = '0;
    ctl_o.mul_sel = MSEL_MAP;
    in_ready_o = 1'b0;
    iter_d     = iter_q;
    res_load   = 1'b0;
    res_esc_d  = 1'b0;
    res_step_d = '0;
    res_mag_d  = '0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.take_xy = in_valid_i;
      end
      ST_MAP: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MSEL_MAP;
      end
      ST_CSET: begin
        ctl_o.load_c  = 1'b1;
        ctl_o.clear_w = 1'b1;
        iter_d        = '0;
        res_load      = (max_iter_i == '0);
      end
      ST_ADD: begin
        ctl_o.load_z = 1'b1;
        if (sts_i.huge) begin
          res_load   = 1'b1;
          res_esc_d  = 1'b1;
          res_step_d = iter_q;
          res_mag_d  = MAG_SAT;
        end
      end
      ST_MUL: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MSEL_SQ;
      end
      ST_CMP: begin
        ctl_o.mul_sel = MSEL_SQ;
        priority if (sts_i.ovf) begin
          res_load   = 1'b1;
          res_esc_d  = 1'b1;
          res_step_d = iter_q;
          res_mag_d  = MAG_SAT;
        end else if (sts_i.over) begin
          res_load   = 1'b1;
          res_esc_d  = 1'b1;
          res_step_d = iter_q;
          res_mag_d  = sts_i.sum_hi;
        end else if (last_iter) begin
          res_load = 1'b1;
        end else begin
          ctl_o.load_w = 1'b1;
          iter_d       = ITER_BITS'(iter_q + 1'b1);
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (out_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iter_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iter_q    <= iter_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_esc_q  <= res_esc_d;
      res_step_q <= res_step_d;
      res_mag_q  <= res_mag_d;
    end
    if (out_load) begin
      m_esc_q  <= res_esc_q;
      m_step_q <= res_step_q;
      m_mag_q  <= res_mag_q;
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_esc_o   = m_esc_q;
  assign out_step_o  = m_step_q;
  assign out_mag_o   = m_mag_q;

  a_iter_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (iter_q < max_iter_i))
    else $error("iteration count passed the limit");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MAP && !in_ready_o))
    else $error("accepted transaction did not start the mapping step");

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_esc_q) |-> (m_step_q == '0 && m_mag_q == '0))
    else $error("non-escaped result carries a step or magnitude");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_esc_q) |-> (m_step_q < max_iter_i))
    else $error("escape step at or beyond the iteration limit");

endmodule

### sv/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time block: registers, sequencer and datapath.
//
//   Channel   Direction  Handshake                       Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready   tdata: column, row
//   m_axis    out        m_axis_tvalid / m_axis_tready   tuser: escaped; tdata: step, mag
//   cfg       in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// Each pixel is mapped to c through the shared three-lane multiplier (ST_MAP,
// then ST_CSET) and then runs up to max_iter orbit steps: each step forms the
// new point (ST_ADD), squares it in the multiplier (ST_MUL) and runs the escape
// compare (ST_CMP). A step that leaves through a component of 16 or more ends
// in ST_ADD. The result then passes ST_DONE into the output register, and the
// next pixel is taken once the block is back in ST_IDLE.
// The input side is not ready while a pixel is in flight; a finished result sits
// in the output register, so a stalled m_axis only holds the next result back.
// The reset is asynchronous and clears control state; the configuration
// registers return to their documented defaults.
module mandelbrot_escape_time_top #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ITER_BITS  = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // Fields from bit 0: column, row, zero padding.
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // Fields from bit 0: escape_step, magnitude_sq, zero padding.
  output logic [((ITER_BITS+mbt_pkg::MAGW+7)/8)*8-1:0] m_axis_tdata,
  // Fields from bit 0: escaped.
  output logic                                       m_axis_tuser,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [mbt_pkg::CFG_IW-1:0]                 cfg_index_i,
  input  logic [mbt_pkg::CFG_DW-1:0]                 cfg_data_i
);
  import mbt_pkg::*;

  localparam int unsigned OUT_W = ((ITER_BITS+MAGW+7)/8)*8;

  logic [QW-1:0]        left_edge_q, top_edge_q;
  logic [STEPW-1:0]     column_step_q, row_step_q;
  logic [ITER_BITS-1:0] max_iter_q;
  logic [MAGW-1:0]      escape_sq_q;

  ctl_t                 ctl;
  sts_t                 sts;
  logic                 out_esc;
  logic [ITER_BITS-1:0] out_step;
  logic [MAGW-1:0]      out_mag;

  // Register writes are always taken; the block must only be written while idle, which it does not enforce itself.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_edge_q   <= 32'hE000_0000;
      top_edge_q    <= 32'h1000_0000;
      column_step_q <= 31'd262144;
      row_step_q    <= 31'd262144;
      max_iter_q    <= ITER_BITS'(8'hFF);
      escape_sq_q   <= 32'h0400_0000;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT_EDGE:   left_edge_q   <= cfg_data_i;
        CFG_TOP_EDGE:    top_edge_q    <= cfg_data_i;
        CFG_COLUMN_STEP: column_step_q <= cfg_data_i[STEPW-1:0];
        CFG_ROW_STEP:    row_step_q    <= cfg_data_i[STEPW-1:0];
        // The iteration limit never exceeds eight bits.
        CFG_MAX_ITER:    max_iter_q    <= cfg_data_i[ITER_BITS-1:0] & ITER_BITS'(8'hFF);
        CFG_ESCAPE_SQ:   escape_sq_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The sequencer walks each pixel through mapping and the orbit loop.
  mbt_ctrl #(
    .ITER_BITS (ITER_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_iter_i  (max_iter_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .ctl_o       (ctl),
    .sts_i       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_esc_o   (out_esc),
    .out_step_o  (out_step),
    .out_mag_o   (out_mag)
  );

  // The datapath holds c and z and owns the shared multiplier.
  mbt_orbit #(
    .COORD_BITS (COORD_BITS)
  ) u_orbit (
    .clk_i         (clk_i),
    .ctl_i         (ctl),
    .column_i      (s_axis_tdata[COORD_BITS-1:0]),
    .row_i         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .left_edge_i   (left_edge_q),
    .top_edge_i    (top_edge_q),
    .column_step_i (column_step_q),
    .row_step_i    (row_step_q),
    .escape_sq_i   (escape_sq_q),
    .sts_o         (sts)
  );

  assign m_axis_tdata = OUT_W'({out_mag, out_step});
  assign m_axis_tuser = out_esc;

endmodule

### tb/mandelbrot_escape_time_top_test.sv
// Testbench for the Mandelbrot escape-time block: drives pixels, predicts results and checks them.
`timescale 1ns / 100ps

module mandelbrot_escape_time_top_test;
  import mbt_pkg::*;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned ITER_BITS  = 8;
  localparam int unsigned PIX_W      = ((2*COORD_BITS+7)/8)*8;
  localparam int unsigned RES_W      = ((ITER_BITS+MAGW+7)/8)*8;

  // The longest pixel runs N = 255 orbit steps.
  localparam int unsigned SETTLE_CYCLES = 800;

  // A pixel coordinate as it travels in s_axis_tdata: column low, row high.
  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
  } pixel_t;

  // The predicted outcome of one pixel.
  typedef struct packed {
    logic                 escaped;
    logic [ITER_BITS-1:0] step;
    logic [MAGW-1:0]      mag;
  } pixel_result_t;

  // Local copy of the view registers, updated on every register transaction.
  typedef struct {
    logic signed [QW-1:0] left_edge;
    logic signed [QW-1:0] top_edge;
    logic [STEPW-1:0]     column_step;
    logic [STEPW-1:0]     row_step;
    logic [ITER_BITS-1:0] max_iter;
    logic [MAGW-1:0]      escape_sq;
  } frame_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // Fields from bit 0: column, row.
  logic [PIX_W-1:0]        s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // Fields from bit 0: escape_step, magnitude_sq.
  logic [RES_W-1:0]        m_axis_tdata;
  // Fields from bit 0: escaped.
  logic                    m_axis_tuser;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IW-1:0]       cfg_index_i = '0;
  logic [CFG_DW-1:0]       cfg_data_i = '0;

  // Pixels waiting to be driven, and results owed by the block in order.
  pixel_t        pixel_queue[$];
  pixel_result_t pending_results[$];
  frame_t        frame;
  int unsigned   fail_count = 0;

  // Driver state.
  pixel_t        next_pixel;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;

  // Monitor state.
  pixel_result_t want;
  logic [15:0]   stall_pattern = 16'hFFFF;
  logic [3:0]    stall_pos = '0;

  mandelbrot_escape_time_top #(
    .COORD_BITS(COORD_BITS),
    .ITER_BITS (ITER_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run, in which every pixel runs
  // 255 orbit steps behind the longest stalls.
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic note_failure(input string msg);
    if (fail_count < 10) begin
      $display("%s", msg);
    end
    fail_count++;
  endtask

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // Reduces an exact product magnitude by 2^sh, rounding toward minus infinity
  // once the sign is applied.
  function automatic logic signed [63:0] floor_scale(input bit neg, input logic [63:0] mag,
                                                     input int unsigned sh);
    logic [63:0] q;
    q = mag >> sh;
    if (neg && ((mag & ((64'd1 << sh) - 64'd1)) != 64'd0)) begin
      q++;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] clamp_q428(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Maps a pixel onto c and runs the orbit z = z*z + c from zero. Components
  // stay below 16 in magnitude at the top of each step, so every square fits
  // 64 bits; only the sum of the two squares needs a carry bit.
  function automatic pixel_result_t escape_time(input frame_t f, input pixel_t px);
    logic signed [63:0] cre, cim, zr, zi, re, im;
    logic [63:0]        ar, ai, sr, si, prod, limit;
    logic [64:0]        sum;
    pixel_result_t      r;
    bit                 done;
    int                 i;
    r    = '0;
    done = 1'b0;
    cre  = clamp_q428($signed({{32{f.left_edge[QW-1]}}, f.left_edge})
                      + $signed({52'd0, px.col} * {33'd0, f.column_step}));
    cim  = clamp_q428($signed({{32{f.top_edge[QW-1]}}, f.top_edge})
                      - $signed({52'd0, px.row} * {33'd0, f.row_step}));
    limit = {f.escape_sq, 32'd0};
    zr = '0;
    zi = '0;
    for (i = 0; i < int'(f.max_iter) && !done; i++) begin
      ar   = abs64(zr);
      ai   = abs64(zi);
      sr   = ar * ar;
      si   = ai * ai;
      prod = ar * ai;
      re   = (sr >= si) ? floor_scale(1'b0, sr - si, 28) : floor_scale(1'b1, si - sr, 28);
      im   = floor_scale((zr < 0) != (zi < 0), prod, 27);
      zr   = re + cre;
      zi   = im + cim;
      ar   = abs64(zr);
      ai   = abs64(zi);
      if (ar[63:32] != 32'd0 || ai[63:32] != 32'd0) begin
        // A component of 16 or more: escaped beyond any radius.
        r    = '{1'b1, i[ITER_BITS-1:0], MAG_SAT};
        done = 1'b1;
      end else begin
        sum = {1'b0, ar * ar} + {1'b0, ai * ai};
        if (sum[64]) begin
          r    = '{1'b1, i[ITER_BITS-1:0], MAG_SAT};
          done = 1'b1;
        end else if (sum[63:0] > limit) begin
          r    = '{1'b1, i[ITER_BITS-1:0], sum[63:32]};
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Sender: pixels leave the queue in bursts of random length, separated by
  // random gaps. A gap of zero gives back-to-back bursts, so some stretches
  // run with no idling at all. The prediction is made the moment the block
  // takes a pixel, against the view registers in force at that time.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(escape_time(frame, pixel_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (pixel_queue.size() != 0) begin
          next_pixel    = pixel_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_pixel;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: tready follows a 16-bit pattern that is redrawn each time it
  // runs out. The patterns range from always ready through random and mostly
  // ready down to one ready bit in sixteen.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_pos     <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result with no pixel outstanding: escaped %0b step %0d mag %h",
                                 m_axis_tuser, m_axis_tdata[ITER_BITS-1:0],
                                 m_axis_tdata[ITER_BITS +: MAGW]));
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser !== want.escaped ||
              m_axis_tdata[ITER_BITS-1:0] !== want.step ||
              m_axis_tdata[ITER_BITS +: MAGW] !== want.mag) begin
            note_failure($sformatf({"pixel result mismatch: escaped %0b (exp %0b), ",
                                    "step %0d (exp %0d), mag %h (exp %h)"},
                                   m_axis_tuser, want.escaped,
                                   m_axis_tdata[ITER_BITS-1:0], want.step,
                                   m_axis_tdata[ITER_BITS +: MAGW], want.mag));
          end
        end
      end
      if (stall_pos == 4'd15) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern <= 16'hFFFF;
          1:       stall_pattern <= 16'($urandom);
          2:       stall_pattern <= 16'($urandom | $urandom);
          default: stall_pattern <= 16'h8000;
        endcase
      end
      m_axis_tready <= stall_pattern[stall_pos];
      stall_pos     <= stall_pos + 1'b1;
    end
  end

  // One register transaction; the local view copy follows the same masking
  // as the hardware registers.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LEFT_EDGE:   frame.left_edge   = value;
      CFG_TOP_EDGE:    frame.top_edge    = value;
      CFG_COLUMN_STEP: frame.column_step = value[STEPW-1:0];
      CFG_ROW_STEP:    frame.row_step    = value[STEPW-1:0];
      CFG_MAX_ITER:    frame.max_iter    = value[ITER_BITS-1:0];
      CFG_ESCAPE_SQ:   frame.escape_sq   = value;
      default: ;
    endcase
  endtask

  task automatic program_frame(input logic [31:0] left, input logic [31:0] top,
                               input logic [31:0] col_step, input logic [31:0] row_step,
                               input logic [31:0] iters, input logic [31:0] esc_sq);
    write_reg(CFG_LEFT_EDGE, left);
    write_reg(CFG_TOP_EDGE, top);
    write_reg(CFG_COLUMN_STEP, col_step);
    write_reg(CFG_ROW_STEP, row_step);
    write_reg(CFG_MAX_ITER, iters);
    write_reg(CFG_ESCAPE_SQ, esc_sq);
  endtask

  task automatic queue_pixel(input int col, input int row);
    pixel_queue.push_back('{row: row[COORD_BITS-1:0], col: col[COORD_BITS-1:0]});
  endtask

  // Returns once every queued pixel has been taken and its result checked.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
  endtask

  initial begin
    logic [31:0] left, top, cstep, rstep, iters, esc;
    int          phase, n;

    // Reset values of the view registers.
    frame.left_edge   = -32'sd536870912;
    frame.top_edge    = 32'sd268435456;
    frame.column_step = 31'd262144;
    frame.row_step    = 31'd262144;
    frame.max_iter    = 8'd255;
    frame.escape_sq   = 32'h0400_0000;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default view, -2..2 by 1..-3 at 2^-10 per pixel, 255 steps, radius 2.
    // Field extremes, points deep inside the set (c = 0, -0.5, the cusp at
    // 0.25), the boundary point c = -2 whose orbit sits exactly on the radius
    // and so never passes the strict compare, a slow escape just past the
    // cusp, and the period-two orbit of c = i.
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(2048, 1024);
    queue_pixel(0, 1024);
    queue_pixel(1536, 1024);
    queue_pixel(2304, 1024);
    queue_pixel(2336, 1024);
    queue_pixel(2048, 0);
    queue_pixel(2048, 2048);
    queue_pixel(12'hAAA, 12'h555);
    queue_pixel(12'h555, 12'hAAA);
    wait_drained();

    // Register extremes: most negative left edge, most positive top edge,
    // largest steps so the mapping saturates both ways, one orbit step and a
    // zero escape radius.
    program_frame(Q_MIN, Q_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(1, 1);
    queue_pixel(2048, 2048);
    wait_drained();

    // Zero iteration limit and zero steps: nothing runs, nothing escapes.
    program_frame(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0400_0000);
    queue_pixel(4095, 4095);
    queue_pixel(0, 0);
    wait_drained();

    // Largest radius. c = 3.5 + 1.656i lands its second point near (13, 13.25):
    // both components under 16, but the sum of squares carries out of 64 bits.
    // The other pixels saturate c and then leave through a component of 16
    // or more.
    program_frame(32'h3800_0000, 32'h1A80_0000, 32'h0010_0000, 32'h0010_0000,
                  32'd255, 32'hFFFF_FFFF);
    queue_pixel(0, 0);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(2048, 2048);
    wait_drained();

    // Random views. Most frame the interesting region at random zoom with a
    // modest step limit; the first runs the full 255 steps and one sets every
    // register from raw random bits.
    for (phase = 0; phase < 8; phase++) begin
      left  = 32'($signed(-671088640) + $signed($urandom_range(0, 402653184)));
      top   = 32'd201326592 + $urandom_range(0, 201326592);
      cstep = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1 << 15, 1 << 18);
      rstep = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1 << 15, 1 << 18);
      iters = (phase == 0) ? 32'd255 : $urandom_range(1, 48);
      case ($urandom_range(0, 5))
        0:       esc = $urandom;
        1:       esc = $urandom_range(0, 32'h0100_0000);
        2:       esc = 32'hFFFF_FFFF;
        default: esc = 32'h0400_0000;
      endcase
      if (phase == 3) begin
        left  = $urandom;
        top   = $urandom;
        cstep = $urandom;
        rstep = $urandom;
        iters = $urandom;
        esc   = $urandom;
      end
      program_frame(left, top, cstep, rstep, iters, esc);
      for (n = 0; n < 166; n++) begin
        queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
